>>> hdl/ffd_pkg.sv
// Shared types, constants and saturation helper for the fractional feedback delay.
`default_nettype none
package ffd_pkg;

   localparam int SAMPLE_W = 24;
   localparam int GAIN_W   = 16;
   localparam int ACC_W    = 42;
   localparam int CSR_W    = 23;

   localparam logic [14:0] FB_MAX    = 15'd32604;
   localparam logic [15:0] MIX_ONE   = 16'd32768;
   localparam logic [31:0] DELAY_MIN = 32'd256;

   typedef enum logic [1:0] {
      CSR_ENABLE   = 2'd0,
      CSR_DELAY    = 2'd1,
      CSR_FEEDBACK = 2'd2,
      CSR_MIX      = 2'd3
   } ffd_csr_type;

   typedef enum logic [1:0] {
      MAC_HOLD = 2'd0,
      MAC_LOAD = 2'd1,
      MAC_ADD  = 2'd2
   } ffd_mac_op_type;

   typedef struct packed {
      ffd_mac_op_type              op;
      logic signed [SAMPLE_W-1:0]  a;
      logic [GAIN_W-1:0]           b;
   } ffd_mac_ctl_type;

   typedef struct packed {
      logic                        en;
      logic signed [SAMPLE_W-1:0]  data;
   } ffd_ring_wr_type;

   // Clip a 28-bit signed value to the 24-bit sample range.
   function automatic logic signed [SAMPLE_W-1:0] sat24(input logic signed [27:0] x);
      logic signed [SAMPLE_W-1:0] r;
      if ((x[27:23] == 5'b00000) || (x[27:23] == 5'b11111)) begin
         r = x[23:0];
      end else if (x[27]) begin
         r = {1'b1, {(SAMPLE_W-1){1'b0}}};
      end else begin
         r = {1'b0, {(SAMPLE_W-1){1'b1}}};
      end
      return r;
   endfunction

endpackage
`default_nettype wire

>>> hdl/ffd_req_if.sv
// Input sample channel: valid/ready handshake with the dry sample.
`default_nettype none
interface ffd_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [ffd_pkg::SAMPLE_W-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface
`default_nettype wire

>>> hdl/ffd_rsp_if.sv
// Output sample channel: valid/ready handshake with the mixed sample.
`default_nettype none
interface ffd_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [ffd_pkg::SAMPLE_W-1:0] mixed;

   modport source (output valid, output mixed, input ready);
   modport sink   (input valid, input mixed, output ready);
endinterface
`default_nettype wire

>>> hdl/fractional_feedback_delay.sv
// Top level: register port, sequencer and output register of the feedback echo.
//
// Mono feedback echo on signed 24-bit samples. Each sample passes through the
// sequencer states in order before its result is presented, and no new sample
// is taken until then: one multiply-accumulate unit is shared over five
// products (two for the interpolation, one for feedback, two for the mix) and
// the history, read through one port, gives its two taps on consecutive cycles. The
// request side is ready again once the result is in the output register, so
// the next sample can start while that result waits to be taken. The history
// needs no clearing pass after reset: entries not yet written read as zero.
// Program the registers only while no sample is in flight.
`default_nettype none
module fractional_feedback_delay #(
   parameter int RING_DEPTH = 32768
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   ffd_req_if.sink                                  req_ch,
   ffd_rsp_if.source                                rsp_ch,
   input  wire logic                                csr_we,
   input  wire logic [1:0]                          csr_index,
   input  wire logic [ffd_pkg::CSR_W-1:0]           csr_wdata
);

   localparam int AW = $clog2(RING_DEPTH);
   localparam logic [31:0]   DELAY_MAX = 32'((RING_DEPTH - 2) * 256);
   localparam logic [AW:0]   DEPTH_X   = (AW+1)'(RING_DEPTH);
   localparam logic [AW-1:0] LAST      = AW'(RING_DEPTH - 1);

   typedef enum logic [3:0] {
      S_IDLE, S_CALC, S_RD_NEW, S_RD_OLD, S_ACC_OLD, S_FBK, S_STORE, S_MIX, S_DONE
   } state_type;

   state_type                           state_ff, state_in;
   logic                                enable_ff;
   logic [22:0]                         delay_ff;
   logic [14:0]                         fb_ff;
   logic [15:0]                         mix_ff;
   logic signed [ffd_pkg::SAMPLE_W-1:0] dry_ff, dry_in;
   logic [AW-1:0]                       di_ff, di_in;
   logic [7:0]                          frac_ff, frac_in;
   logic [AW-1:0]                       newer_ff, newer_in;
   logic signed [ffd_pkg::SAMPLE_W-1:0] wet_ff, wet_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic signed [ffd_pkg::SAMPLE_W-1:0] rsp_mixed_ff, rsp_mixed_in;

   logic [31:0]                         delay_cl;
   logic [14:0]                         fb_cl;
   logic [15:0]                         mix_cl;
   logic [AW:0]                         diff;
   logic [AW-1:0]                       older;
   logic [AW-1:0]                       rd_addr;
   logic [AW-1:0]                       wp;
   logic signed [ffd_pkg::SAMPLE_W-1:0] rd_data;
   logic signed [ffd_pkg::ACC_W-1:0]    acc;
   logic signed [27:0]                  stored_sum;
   ffd_pkg::ffd_mac_ctl_type            mac_ctl;
   ffd_pkg::ffd_ring_wr_type            ring_wr;
   logic                                out_free;
   logic                                req_xfer;

   // Register writes; unknown indexes cannot occur with a two-bit index.
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         delay_ff  <= 23'd1536000;
         fb_ff     <= 15'd16384;
         mix_ff    <= 16'd16384;
      end else if (csr_we) begin
         unique case (csr_index)
            ffd_pkg::CSR_ENABLE:   enable_ff <= csr_wdata[0];
            ffd_pkg::CSR_DELAY:    delay_ff  <= csr_wdata[22:0];
            ffd_pkg::CSR_FEEDBACK: fb_ff     <= csr_wdata[14:0];
            ffd_pkg::CSR_MIX:      mix_ff    <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      priority if ({9'd0, delay_ff} < ffd_pkg::DELAY_MIN) begin
         delay_cl = ffd_pkg::DELAY_MIN;
      end else if ({9'd0, delay_ff} > DELAY_MAX) begin
         delay_cl = DELAY_MAX;
      end else begin
         delay_cl = {9'd0, delay_ff};
      end
      fb_cl  = (fb_ff > ffd_pkg::FB_MAX) ? ffd_pkg::FB_MAX : fb_ff;
      mix_cl = (mix_ff > ffd_pkg::MIX_ONE) ? ffd_pkg::MIX_ONE : mix_ff;
   end

   assign diff  = {1'b0, wp} - {1'b0, di_ff};
   assign older = (newer_ff == '0) ? LAST : newer_ff - 1'b1;

   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign req_xfer = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == S_IDLE) && !reset;

   assign stored_sum = 28'(dry_ff) + {acc[41], acc[41:15]};

   always_comb begin
      state_in     = state_ff;
      dry_in       = dry_ff;
      di_in        = di_ff;
      frac_in      = frac_ff;
      newer_in     = newer_ff;
      wet_in       = wet_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_mixed_in = rsp_mixed_ff;
      rd_addr      = newer_ff;
      mac_ctl      = '{op: ffd_pkg::MAC_HOLD, a: rd_data, b: '0};
      ring_wr      = '{en: 1'b0, data: dry_ff};
      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               dry_in   = req_ch.sample;
               di_in    = delay_cl[AW+7:8];
               frac_in  = delay_cl[7:0];
               state_in = S_CALC;
            end
         end
         S_CALC: begin
            newer_in = diff[AW] ? AW'(diff + DEPTH_X) : diff[AW-1:0];
            state_in = S_RD_NEW;
         end
         S_RD_NEW: begin
            state_in = S_RD_OLD;
         end
         S_RD_OLD: begin
            rd_addr  = older;
            mac_ctl  = '{op: ffd_pkg::MAC_LOAD, a: rd_data,
                         b: 16'(9'd256 - {1'b0, frac_ff})};
            state_in = S_ACC_OLD;
         end
         S_ACC_OLD: begin
            mac_ctl  = '{op: ffd_pkg::MAC_ADD, a: rd_data, b: {8'd0, frac_ff}};
            state_in = S_FBK;
         end
         S_FBK: begin
            // Interpolated tap is the weighted sum shifted down by eight.
            wet_in   = acc[31:8];
            mac_ctl  = '{op: ffd_pkg::MAC_LOAD, a: acc[31:8], b: {1'b0, fb_cl}};
            state_in = S_STORE;
         end
         S_STORE: begin
            ring_wr  = '{en: 1'b1,
                         data: enable_ff ? ffd_pkg::sat24(stored_sum) : dry_ff};
            mac_ctl  = '{op: ffd_pkg::MAC_LOAD, a: dry_ff,
                         b: ffd_pkg::MIX_ONE - mix_cl};
            state_in = S_MIX;
         end
         S_MIX: begin
            mac_ctl  = '{op: ffd_pkg::MAC_ADD, a: wet_ff, b: mix_cl};
            state_in = S_DONE;
         end
         S_DONE: begin
            // Hold until the output register is free.
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_mixed_in = enable_ff ? ffd_pkg::sat24({acc[41], acc[41:15]}) : dry_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      dry_ff       <= dry_in;
      di_ff        <= di_in;
      frac_ff      <= frac_in;
      newer_ff     <= newer_in;
      wet_ff       <= wet_in;
      rsp_mixed_ff <= rsp_mixed_in;
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.mixed = rsp_mixed_ff;

   ffd_mac u_mac (
      .clock (clock),
      .ctl   (mac_ctl),
      .acc   (acc)
   );

   ffd_ring #(
      .DEPTH (RING_DEPTH),
      .AW    (AW)
   ) u_ring (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (rd_addr),
      .wr      (ring_wr),
      .rd_data (rd_data),
      .wr_pos  (wp)
   );

endmodule
`default_nettype wire

>>> hdl/ffd_mac.sv
// Shared signed-by-unsigned multiply-accumulate unit used by every product.
`default_nettype none
module ffd_mac (
   input  wire logic                                 clock,
   input  wire ffd_pkg::ffd_mac_ctl_type             ctl,
   output logic signed [ffd_pkg::ACC_W-1:0]          acc
);

   localparam int PROD_W = ffd_pkg::SAMPLE_W + ffd_pkg::GAIN_W + 1;

   logic signed [PROD_W-1:0]         prod;
   logic signed [ffd_pkg::ACC_W-1:0] acc_ff;
   logic signed [ffd_pkg::ACC_W-1:0] acc_in;

   assign prod = ctl.a * $signed({1'b0, ctl.b});

   always_comb begin
      unique case (ctl.op)
         ffd_pkg::MAC_LOAD: acc_in = ffd_pkg::ACC_W'(prod);
         ffd_pkg::MAC_ADD:  acc_in = acc_ff + ffd_pkg::ACC_W'(prod);
         default:           acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;

endmodule
`default_nettype wire

>>> hdl/ffd_ring.sv
// Circular sample history with write pointer and fill tracking for unwritten entries.
`default_nettype none
module ffd_ring #(
   parameter int DEPTH = 32768,
   parameter int AW    = 15
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic [AW-1:0]                        rd_addr,
   input  wire ffd_pkg::ffd_ring_wr_type             wr,
   output logic signed [ffd_pkg::SAMPLE_W-1:0]       rd_data,
   output logic [AW-1:0]                             wr_pos
);

   localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

   logic signed [ffd_pkg::SAMPLE_W-1:0] mem [DEPTH];
   logic signed [ffd_pkg::SAMPLE_W-1:0] rdata_ff;
   logic                                rvalid_ff;
   logic [AW-1:0]                       wp_ff;
   logic                                full_ff;

   // Entries are written in order from zero, so anything below the pointer
   // (or everything once wrapped) holds data; the rest still reads as zero.
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wp_ff] <= wr.data;
      end
      rdata_ff  <= mem[rd_addr];
      rvalid_ff <= full_ff || (rd_addr < wp_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff   <= '0;
         full_ff <= 1'b0;
      end else if (wr.en) begin
         if (wp_ff == LAST) begin
            wp_ff   <= '0;
            full_ff <= 1'b1;
         end else begin
            wp_ff <= wp_ff + 1'b1;
         end
      end
   end

   assign rd_data = rvalid_ff ? rdata_ff : '0;
   assign wr_pos  = wp_ff;

endmodule
`default_nettype wire

>>> hdl/ffd_checker.sv
// Port-level checks for the feedback echo, bound to the top level.
`default_nettype none
module ffd_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_valid,
   input wire logic                                req_ready,
   input wire logic                                rsp_valid,
   input wire logic                                rsp_ready,
   input wire logic [ffd_pkg::SAMPLE_W-1:0]        rsp_mixed
);

   // A stalled result keeps its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_mixed))
      else $error("result changed while stalled");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // One sample at a time: a transfer closes the request side.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted back to back");

   // A result never appears the cycle right after a transfer.
   a_no_instant_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_valid && req_ready))
      else $error("result too early");

endmodule

bind fractional_feedback_delay ffd_checker u_ffd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_mixed (rsp_ch.mixed)
);
`default_nettype wire
